// ----- sv/aie_pkg.sv -----
package aie_pkg;

  // instruction classes, decided in the front part
  localparam logic [2:0] CLS_DP    = 3'd0;
  localparam logic [2:0] CLS_PSR   = 3'd1;
  localparam logic [2:0] CLS_BX    = 3'd2;
  localparam logic [2:0] CLS_MUL   = 3'd3;
  localparam logic [2:0] CLS_MULL  = 3'd4;
  localparam logic [2:0] CLS_BR    = 3'd5;
  localparam logic [2:0] CLS_UNSUP = 3'd6;

  localparam logic [31:0] STATUS_RESET = 32'h0000_00D3;
  localparam int unsigned QUEUE_DEPTH  = 2;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  cls;
  } entry_t;

endpackage

// ----- sv/arm_instruction_execute_core.sv -----
// An accepted instruction is written into the queue, then executed into the output
// register. Throughput: one instruction per cycle while the output is not stalled;
// the execute unit with its register file, status word and multiplier sets that rate.
// Reset: synchronous rst clears the register file and saved status banks, loads
// status 0x000000D3, and empties the queue and the output register.
module arm_instruction_execute_core #(
  parameter int unsigned QUEUE_DEPTH = aie_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] instruction_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        condition_passed,
  output logic        unsupported_group,
  output logic        first_write_enable,
  output logic [3:0]  first_write_index,
  output logic [31:0] first_write_value,
  output logic        second_write_enable,
  output logic [3:0]  second_write_index,
  output logic [31:0] second_write_value,
  output logic [31:0] status_after,
  output logic [31:0] next_pc,
  output logic [2:0]  cycle_cost
);

  aie_pkg::entry_t front_entry;
  aie_pkg::entry_t head;
  logic            full;
  logic            not_empty;
  logic            pop;

  assign in_stall = full;

  aie_front u_front (
    .instruction_word (instruction_word),
    .entry            (front_entry)
  );

  aie_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (in_valid && !full),
    .push_entry (front_entry),
    .full       (full),
    .pop        (pop),
    .not_empty  (not_empty),
    .head       (head)
  );

  aie_exec u_exec (
    .clk                 (clk),
    .rst                 (rst),
    .q_valid             (not_empty),
    .q_head              (head),
    .q_pop               (pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .condition_passed    (condition_passed),
    .unsupported_group   (unsupported_group),
    .first_write_enable  (first_write_enable),
    .first_write_index   (first_write_index),
    .first_write_value   (first_write_value),
    .second_write_enable (second_write_enable),
    .second_write_index  (second_write_index),
    .second_write_value  (second_write_value),
    .status_after        (status_after),
    .next_pc             (next_pc),
    .cycle_cost          (cycle_cost)
  );

endmodule

// ----- sv/aie_front.sv -----
module aie_front (
  input  logic [31:0]      instruction_word,
  output aie_pkg::entry_t  entry
);

  logic [31:0] w;
  assign w = instruction_word;

  // classify in priority order; the first matching pattern wins
  always_comb begin
    entry.word = w;
    priority if (w[27:4] == 24'h12FFF1) begin
      entry.cls = aie_pkg::CLS_BX;
    end else if (w[27:22] == 6'd0 && w[7:4] == 4'b1001) begin
      entry.cls = aie_pkg::CLS_MUL;
    end else if (w[27:23] == 5'd1 && w[7:4] == 4'b1001) begin
      entry.cls = aie_pkg::CLS_MULL;
    end else if (w[27:25] == 3'd0 && w[7] && w[4]) begin
      entry.cls = aie_pkg::CLS_UNSUP;
    end else if (w[27:26] == 2'd0 && w[24:23] == 2'b10 && !w[20]) begin
      entry.cls = aie_pkg::CLS_PSR;
    end else if (w[27:26] == 2'd0) begin
      entry.cls = aie_pkg::CLS_DP;
    end else if (w[27:25] == 3'b101) begin
      entry.cls = aie_pkg::CLS_BR;
    end else begin
      entry.cls = aie_pkg::CLS_UNSUP;
    end
  end

endmodule

// ----- sv/aie_queue.sv -----
module aie_queue #(
  parameter int unsigned DEPTH = aie_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  aie_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output aie_pkg::entry_t head
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  aie_pkg::entry_t slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  // store incoming transaction
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- sv/aie_exec.sv -----
module aie_exec (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  aie_pkg::entry_t q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            condition_passed,
  output logic            unsupported_group,
  output logic            first_write_enable,
  output logic [3:0]      first_write_index,
  output logic [31:0]     first_write_value,
  output logic            second_write_enable,
  output logic [3:0]      second_write_index,
  output logic [31:0]     second_write_value,
  output logic [31:0]     status_after,
  output logic [31:0]     next_pc,
  output logic [2:0]      cycle_cost
);

  logic [31:0] rf [16];
  logic [31:0] status;
  logic [31:0] spsr [5];

  function automatic logic [31:0] ror32(input logic [31:0] v, input logic [4:0] n);
    logic [63:0] d;
    d = {v, v} >> n;
    return d[31:0];
  endfunction

  logic [31:0] op, pc4, rn, rm, rs, rdv;
  logic        cin, n_f, z_f, c_f, v_f, pass;
  logic        w0e, w1e, unsup;
  logic [3:0]  w0i, w1i;
  logic [31:0] w0v, w1v, st_n;
  logic [2:0]  cyc;
  logic [31:0] b, res, ax, ay, mval, mmask, mul32;
  logic        sc, aci, arith, sflag;
  logic [32:0] sum;
  logic [4:0]  sa, rot;
  logic [7:0]  ra;
  logic [2:0]  bank;
  logic        bank_ok;
  logic [63:0] prod, lres;
  logic [65:0] sprod;
  logic [3:0]  code;
  logic [31:0] off;

  assign op    = q_head.word;
  assign q_pop = q_valid && (!out_valid || !out_stall);
  assign pc4   = rf[15] + 32'd4;
  assign rn    = (op[19:16] == 4'd15) ? pc4 : rf[op[19:16]];
  assign rm    = (op[3:0]   == 4'd15) ? pc4 : rf[op[3:0]];
  assign rs    = (op[11:8]  == 4'd15) ? pc4 : rf[op[11:8]];
  assign rdv   = (op[15:12] == 4'd15) ? pc4 : rf[op[15:12]];
  assign n_f   = status[31];
  assign z_f   = status[30];
  assign c_f   = status[29];
  assign v_f   = status[28];
  assign cin   = c_f;

  // evaluate condition field
  always_comb begin
    unique case (op[31:28])
      4'h0: pass = z_f;
      4'h1: pass = !z_f;
      4'h2: pass = c_f;
      4'h3: pass = !c_f;
      4'h4: pass = n_f;
      4'h5: pass = !n_f;
      4'h6: pass = v_f;
      4'h7: pass = !v_f;
      4'h8: pass = c_f && !z_f;
      4'h9: pass = !c_f || z_f;
      4'hA: pass = n_f == v_f;
      4'hB: pass = n_f != v_f;
      4'hC: pass = !z_f && (n_f == v_f);
      4'hD: pass = z_f || (n_f != v_f);
      4'hE: pass = 1'b1;
      default: pass = 1'b0;
    endcase
  end

  // saved status bank from mode bits
  always_comb begin
    bank_ok = 1'b1;
    unique case (status[4:0])
      5'h11: bank = 3'd0;
      5'h13: bank = 3'd1;
      5'h17: bank = 3'd2;
      5'h12: bank = 3'd3;
      5'h1B: bank = 3'd4;
      default: begin
        bank    = 3'd0;
        bank_ok = 1'b0;
      end
    endcase
  end

  // barrel shifter operand
  always_comb begin
    sa  = op[11:7];
    ra  = rs[7:0];
    rot = {op[11:8], 1'b0};
    b   = rm;
    sc  = cin;
    if (op[25]) begin
      if (rot == 5'd0) begin
        b  = {24'd0, op[7:0]};
        sc = cin;
      end else begin
        b  = ror32({24'd0, op[7:0]}, rot);
        sc = b[31];
      end
    end else if (op[4]) begin
      if (ra == 8'd0) begin
        b  = rm;
        sc = cin;
      end else begin
        unique case (op[6:5])
          2'd0: begin
            if (ra < 8'd32) begin
              b  = rm << ra[4:0];
              sc = rm[5'(6'd32 - {1'b0, ra[4:0]})];
            end else begin
              b  = '0;
              sc = (ra == 8'd32) ? rm[0] : 1'b0;
            end
          end
          2'd1: begin
            if (ra < 8'd32) begin
              b  = rm >> ra[4:0];
              sc = rm[ra[4:0] - 5'd1];
            end else begin
              b  = '0;
              sc = (ra == 8'd32) ? rm[31] : 1'b0;
            end
          end
          2'd2: begin
            if (ra < 8'd32) begin
              b  = $unsigned($signed(rm) >>> ra[4:0]);
              sc = rm[ra[4:0] - 5'd1];
            end else begin
              b  = {32{rm[31]}};
              sc = rm[31];
            end
          end
          default: begin
            if (ra[4:0] == 5'd0) begin
              b  = rm;
              sc = rm[31];
            end else begin
              b  = ror32(rm, ra[4:0]);
              sc = rm[ra[4:0] - 5'd1];
            end
          end
        endcase
      end
    end else begin
      unique case (op[6:5])
        2'd0: begin
          if (sa == 5'd0) begin
            b  = rm;
            sc = cin;
          end else begin
            b  = rm << sa;
            sc = rm[5'(6'd32 - {1'b0, sa})];
          end
        end
        2'd1: begin
          b  = (sa == 5'd0) ? '0 : rm >> sa;
          sc = (sa == 5'd0) ? rm[31] : rm[sa - 5'd1];
        end
        2'd2: begin
          b  = (sa == 5'd0) ? {32{rm[31]}} : $unsigned($signed(rm) >>> sa);
          sc = (sa == 5'd0) ? rm[31] : rm[sa - 5'd1];
        end
        default: begin
          b  = (sa == 5'd0) ? {cin, rm[31:1]} : ror32(rm, sa);
          sc = (sa == 5'd0) ? rm[0] : rm[sa - 5'd1];
        end
      endcase
    end
  end

  // data processing ALU
  always_comb begin
    code  = op[24:21];
    arith = 1'b1;
    ax    = rn;
    ay    = b;
    aci   = 1'b0;
    unique case (code)
      4'h2, 4'hA: begin ay = ~b; aci = 1'b1; end
      4'h3:       begin ax = b; ay = ~rn; aci = 1'b1; end
      4'h4, 4'hB: aci = 1'b0;
      4'h5:       aci = cin;
      4'h6:       begin ay = ~b; aci = cin; end
      4'h7:       begin ax = b; ay = ~rn; aci = cin; end
      default:    arith = 1'b0;
    endcase
    sum = {1'b0, ax} + {1'b0, ay} + {32'd0, aci};
    unique case (code)
      4'h0, 4'h8: res = rn & b;
      4'h1, 4'h9: res = rn ^ b;
      4'hC:       res = rn | b;
      4'hD:       res = b;
      4'hE:       res = rn & ~b;
      4'hF:       res = ~b;
      default:    res = sum[31:0];
    endcase
  end

  // multipliers
  assign mul32 = rm * rs + (op[21] ? rdv : 32'd0);
  assign sprod = $signed({op[22] & rm[31], rm}) * $signed({op[22] & rs[31], rs});
  assign prod  = sprod[63:0];
  assign lres  = prod + (op[21] ? {rn, rdv} : 64'd0);

  // execute one transaction
  always_comb begin
    w0e   = 1'b0; w0i = '0; w0v = '0;
    w1e   = 1'b0; w1i = '0; w1v = '0;
    st_n  = status;
    cyc   = 3'd1;
    unsup = 1'b0;
    mval  = op[25] ? ror32({24'd0, op[7:0]}, {op[11:8], 1'b0}) : rm;
    mmask = {{8{op[19]}}, 16'd0, {8{op[16]}}};
    sflag = op[20] || (op[24:23] == 2'b10);
    off   = {{8{op[23]}}, op[23:0]};
    if (pass) begin
      unique case (q_head.cls)
        aie_pkg::CLS_BX: begin
          st_n[5] = rm[0];
          w0e = 1'b1; w0i = 4'd15; w0v = {rm[31:1], 1'b0};
          cyc = 3'd3;
        end
        aie_pkg::CLS_MUL: begin
          w0e = 1'b1; w0i = op[19:16]; w0v = mul32;
          if (op[20]) begin
            st_n[31] = mul32[31];
            st_n[30] = (mul32 == '0);
          end
          cyc = op[21] ? 3'd4 : 3'd3;
        end
        aie_pkg::CLS_MULL: begin
          w0e = 1'b1; w0i = op[15:12]; w0v = lres[31:0];
          w1e = 1'b1; w1i = op[19:16]; w1v = lres[63:32];
          if (op[20]) begin
            st_n[31] = lres[63];
            st_n[30] = (lres == '0);
          end
          cyc = op[21] ? 3'd5 : 3'd4;
        end
        aie_pkg::CLS_PSR: begin
          if (!op[21]) begin
            w0e = 1'b1; w0i = op[15:12];
            w0v = (op[22] && bank_ok) ? spsr[bank] : status;
          end else if (!op[22]) begin
            st_n = (status & ~mmask) | (mval & mmask);
          end
        end
        aie_pkg::CLS_DP: begin
          if (sflag) begin
            if (arith) begin
              st_n[31] = res[31];
              st_n[30] = (res == '0);
              st_n[29] = sum[32];
              st_n[28] = (~(ax[31] ^ ay[31])) & (ax[31] ^ res[31]);
            end else begin
              st_n[31] = res[31];
              st_n[30] = (res == '0);
              st_n[29] = sc;
            end
          end
          if (op[24:23] != 2'b10) begin
            w0e = 1'b1; w0i = op[15:12]; w0v = res;
            if (op[15:12] == 4'd15) begin
              cyc = 3'd3;
            end
          end
        end
        aie_pkg::CLS_BR: begin
          w0e = 1'b1; w0i = 4'd15; w0v = pc4 + 32'd4 + {off[29:0], 2'b00};
          if (op[24]) begin
            w1e = 1'b1; w1i = 4'd14; w1v = pc4;
          end
          cyc = 3'd3;
        end
        default: unsup = 1'b1;
      endcase
    end
  end

  // commit architectural state; the second write wins over the first
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        rf[i] <= '0;
      end
      for (int i = 0; i < 5; i++) begin
        spsr[i] <= '0;
      end
      status <= aie_pkg::STATUS_RESET;
    end else if (q_pop) begin
      for (int i = 0; i < 16; i++) begin
        if (w1e && w1i == 4'(i)) begin
          rf[i] <= w1v;
        end else if (w0e && w0i == 4'(i)) begin
          rf[i] <= w0v;
        end else if (i == 15) begin
          rf[i] <= pc4;
        end
      end
      status <= st_n;
      if (pass && q_head.cls == aie_pkg::CLS_PSR && op[21] && op[22] && bank_ok) begin
        spsr[bank] <= (spsr[bank] & ~mmask) | (mval & mmask);
      end
    end
  end

  // hold result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      condition_passed    <= pass;
      unsupported_group   <= unsup;
      first_write_enable  <= w0e;
      first_write_index   <= w0i;
      first_write_value   <= w0v;
      second_write_enable <= w1e;
      second_write_index  <= w1i;
      second_write_value  <= w1v;
      status_after        <= st_n;
      next_pc             <= (w1e && w1i == 4'd15) ? w1v :
                             (w0e && w0i == 4'd15) ? w0v : pc4;
      cycle_cost          <= cyc;
    end
  end

endmodule

// ----- sv/aie_checker.sv -----
module aie_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        condition_passed,
  input logic        unsupported_group,
  input logic        first_write_enable,
  input logic [3:0]  first_write_index,
  input logic [31:0] first_write_value,
  input logic        second_write_enable,
  input logic [3:0]  second_write_index,
  input logic [31:0] next_pc,
  input logic [2:0]  cycle_cost
);

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // reset empties the output
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // failed condition does nothing
  a_skip: assert property (@(posedge clk) disable iff (rst)
    out_valid && !condition_passed |->
      !first_write_enable && !second_write_enable && cycle_cost == 3'd1)
    else $error("failed condition had effect");

  // unsupported group only advances
  a_unsup: assert property (@(posedge clk) disable iff (rst)
    out_valid && unsupported_group |->
      condition_passed && !first_write_enable && cycle_cost == 3'd1)
    else $error("unsupported instruction had effect");

  // write to r15 becomes next pc
  a_pc: assert property (@(posedge clk) disable iff (rst)
    out_valid && first_write_enable && first_write_index == 4'd15 &&
    !(second_write_enable && second_write_index == 4'd15) |->
      next_pc == first_write_value)
    else $error("pc write lost");

endmodule

bind arm_instruction_execute_core aie_checker u_aie_checker (
  .clk                 (clk),
  .rst                 (rst),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .condition_passed    (condition_passed),
  .unsupported_group   (unsupported_group),
  .first_write_enable  (first_write_enable),
  .first_write_index   (first_write_index),
  .first_write_value   (first_write_value),
  .second_write_enable (second_write_enable),
  .second_write_index  (second_write_index),
  .next_pc             (next_pc),
  .cycle_cost          (cycle_cost)
);
